// ===== src/gmdp_pkg.sv =====
// types, constants and control words shared by the grid maze path search
package gmdp_pkg;

	localparam int CELLS   = 64;
	localparam int ADDR_W  = 6;
	localparam int DEPTH_W = 7;
	localparam int ENTRY_W = 8;

	typedef logic [1:0] dir_t;

	localparam dir_t DIR_RIGHT = 2'd0;
	localparam dir_t DIR_DOWN  = 2'd1;
	localparam dir_t DIR_LEFT  = 2'd2;
	localparam dir_t DIR_UP    = 2'd3;

	localparam logic FUNC_LOAD   = 1'b0;
	localparam logic FUNC_SEARCH = 1'b1;

	typedef enum logic [10:0] {
		S_CLR_OPEN  = 11'b000_0000_0001,
		S_IDLE      = 11'b000_0000_0010,
		S_CLR_VISIT = 11'b000_0000_0100,
		S_INIT      = 11'b000_0000_1000,
		S_STEP      = 11'b000_0001_0000,
		S_CHECK     = 11'b000_0010_0000,
		S_POP       = 11'b000_0100_0000,
		S_EMIT_RD   = 11'b000_1000_0000,
		S_EMIT_WR   = 11'b001_0000_0000,
		S_LAST      = 11'b010_0000_0000,
		S_FAIL      = 11'b100_0000_0000
	} state_t;

	typedef struct packed {
		logic sweep_open;
		logic sweep_visit;
		logic load;
		logic start;
		logic init;
		logic step;
		logic check;
		logic pop;
		logic out_path;
		logic out_last;
		logic out_fail;
	} cmd_t;

	typedef struct packed {
		logic origin;
		logic cnt_done;
		logic open0;
		logic hit;
		logic pop;
		logic empty;
		logic emit_more;
		logic out_free;
	} sts_t;

endpackage

// ===== src/gmdp_ram.sv =====
// generic single write port ram with registered read
module gmdp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== src/gmdp_ctrl.sv =====
// search controller state machine
module gmdp_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	input  logic          func,
	input  gmdp_pkg::sts_t sts,
	output logic          item_stall,
	output gmdp_pkg::cmd_t cmd
);

	gmdp_pkg::state_t state_q, state_d;
	logic accept;

	assign accept     = item_valid && (state_q == gmdp_pkg::S_IDLE);
	assign item_stall = (state_q != gmdp_pkg::S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gmdp_pkg::S_CLR_OPEN;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			gmdp_pkg::S_CLR_OPEN: begin
				cmd.sweep_open = 1'b1;
				if (sts.cnt_done) begin
					state_d = gmdp_pkg::S_IDLE;
				end
			end
			gmdp_pkg::S_IDLE: begin
				if (accept) begin
					if (func == gmdp_pkg::FUNC_SEARCH) begin
						cmd.start = 1'b1;
						state_d   = sts.origin ? gmdp_pkg::S_LAST : gmdp_pkg::S_CLR_VISIT;
					end else begin
						cmd.load = 1'b1;
					end
				end
			end
			gmdp_pkg::S_CLR_VISIT: begin
				cmd.sweep_visit = 1'b1;
				if (sts.cnt_done) begin
					state_d = gmdp_pkg::S_INIT;
				end
			end
			gmdp_pkg::S_INIT: begin
				cmd.init = 1'b1;
				state_d  = sts.open0 ? gmdp_pkg::S_STEP : gmdp_pkg::S_FAIL;
			end
			gmdp_pkg::S_STEP: begin
				cmd.step = 1'b1;
				state_d  = gmdp_pkg::S_CHECK;
			end
			gmdp_pkg::S_CHECK: begin
				cmd.check = 1'b1;
				if (sts.hit) begin
					state_d = gmdp_pkg::S_EMIT_RD;
				end else if (sts.pop) begin
					state_d = sts.empty ? gmdp_pkg::S_FAIL : gmdp_pkg::S_POP;
				end else begin
					state_d = gmdp_pkg::S_STEP;
				end
			end
			gmdp_pkg::S_POP: begin
				cmd.pop = 1'b1;
				state_d = gmdp_pkg::S_STEP;
			end
			gmdp_pkg::S_EMIT_RD: begin
				state_d = gmdp_pkg::S_EMIT_WR;
			end
			gmdp_pkg::S_EMIT_WR: begin
				if (sts.out_free) begin
					cmd.out_path = 1'b1;
					state_d      = sts.emit_more ? gmdp_pkg::S_EMIT_RD : gmdp_pkg::S_LAST;
				end
			end
			gmdp_pkg::S_LAST: begin
				if (sts.out_free) begin
					cmd.out_last = 1'b1;
					state_d      = gmdp_pkg::S_IDLE;
				end
			end
			gmdp_pkg::S_FAIL: begin
				if (sts.out_free) begin
					cmd.out_fail = 1'b1;
					state_d      = gmdp_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = gmdp_pkg::S_CLR_OPEN;
			end
		endcase
	end

endmodule

// ===== src/gmdp_datapath.sv =====
// grid, visited map, search stack, neighbour logic and result register
module gmdp_datapath #(
	parameter int GRID_SIZE = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  gmdp_pkg::cmd_t cmd,
	input  logic [2:0]     cell_row,
	input  logic [2:0]     cell_col,
	input  logic           cell_open,
	input  logic [2:0]     target_row,
	input  logic [2:0]     target_col,
	input  logic           path_stall,
	output gmdp_pkg::sts_t sts,
	output logic           path_valid,
	output logic [2:0]     path_row,
	output logic [2:0]     path_col,
	output logic           found,
	output logic           last
);

	localparam logic [3:0] GRID_N = 4'(GRID_SIZE);

	logic [gmdp_pkg::DEPTH_W-1:0] depth_q, depth_after;
	logic [gmdp_pkg::ADDR_W-1:0]  cnt_q;
	logic [gmdp_pkg::ADDR_W-1:0]  top_cell_q, nb_cell_q;
	gmdp_pkg::dir_t               top_dir_q;
	logic                         nb_inside_q, nb_dir3_q, nb_tgt_q;
	logic [2:0]                   trow_q, tcol_q;
	logic                         out_valid_q, out_found_q, out_last_q;
	logic [2:0]                   out_row_q, out_col_q;

	logic [2:0] cur_r, cur_c, nb_r, nb_c;
	logic       nb_in;
	logic       hit, push, popped;
	logic       out_free;
	logic [gmdp_pkg::DEPTH_W-1:0] emit_lim;

	logic                          open_we, open_rd;
	logic [gmdp_pkg::ADDR_W-1:0]   open_waddr, open_raddr;
	logic                          open_wdata;
	logic                          vis_we, vis_rd, vis_wdata;
	logic [gmdp_pkg::ADDR_W-1:0]   vis_waddr;
	logic                          stk_we;
	logic [gmdp_pkg::ADDR_W-1:0]   stk_waddr, stk_raddr;
	logic [gmdp_pkg::ENTRY_W-1:0]  stk_wdata, stk_rd;

	// neighbour of the top frame in its current direction
	always_comb begin
		cur_r = top_cell_q[5:3];
		cur_c = top_cell_q[2:0];
		nb_r  = cur_r;
		nb_c  = cur_c;
		nb_in = 1'b0;
		unique case (top_dir_q)
			gmdp_pkg::DIR_RIGHT: begin
				nb_in = ({1'b0, cur_c} + 4'd1) < GRID_N;
				nb_c  = cur_c + 3'd1;
			end
			gmdp_pkg::DIR_DOWN: begin
				nb_in = ({1'b0, cur_r} + 4'd1) < GRID_N;
				nb_r  = cur_r + 3'd1;
			end
			gmdp_pkg::DIR_LEFT: begin
				nb_in = (cur_c != 3'd0);
				nb_c  = cur_c - 3'd1;
			end
			gmdp_pkg::DIR_UP: begin
				nb_in = (cur_r != 3'd0);
				nb_r  = cur_r - 3'd1;
			end
			default: begin
				nb_in = 1'b0;
			end
		endcase
	end

	assign depth_after = nb_dir3_q ? (depth_q - 7'd1) : depth_q;
	assign hit    = nb_inside_q && open_rd && nb_tgt_q;
	assign push   = nb_inside_q && open_rd && !nb_tgt_q && !vis_rd
	                && (depth_after < 7'(gmdp_pkg::CELLS));
	assign popped = nb_dir3_q && !hit && !push;

	assign out_free = !out_valid_q || !path_stall;
	assign emit_lim = depth_q[6] ? 7'(gmdp_pkg::CELLS - 1) : depth_q;

	assign sts.origin    = (target_row == 3'd0) && (target_col == 3'd0);
	assign sts.cnt_done  = (cnt_q == 6'(gmdp_pkg::CELLS - 1));
	assign sts.open0     = open_rd;
	assign sts.hit       = hit;
	assign sts.pop       = popped;
	assign sts.empty     = (depth_after == 7'd0);
	assign sts.emit_more = ({1'b0, cnt_q} + 7'd1) < emit_lim;
	assign sts.out_free  = out_free;

	// open map ports
	assign open_we    = cmd.sweep_open
	                    || (cmd.load && ({1'b0, cell_row} < GRID_N) && ({1'b0, cell_col} < GRID_N));
	assign open_waddr = cmd.sweep_open ? cnt_q : {cell_row, cell_col};
	assign open_wdata = cmd.sweep_open ? 1'b0 : cell_open;
	assign open_raddr = cmd.step ? {nb_r, nb_c} : '0;

	// visited map ports
	assign vis_we    = cmd.sweep_visit || (cmd.init && open_rd) || (cmd.check && push);
	assign vis_waddr = cmd.sweep_visit ? cnt_q : (cmd.init ? '0 : nb_cell_q);
	assign vis_wdata = !cmd.sweep_visit;

	// stack ports: entry is {next direction, cell}
	always_comb begin
		stk_we    = 1'b0;
		stk_waddr = '0;
		stk_wdata = '0;
		if (cmd.init) begin
			stk_we = open_rd;
		end else if (cmd.step) begin
			stk_we    = (top_dir_q != gmdp_pkg::DIR_UP);
			stk_waddr = 6'(depth_q - 7'd1);
			stk_wdata = {top_dir_q + 2'd1, top_cell_q};
		end else if (cmd.check) begin
			stk_we    = push;
			stk_waddr = depth_after[5:0];
			stk_wdata = {gmdp_pkg::DIR_RIGHT, nb_cell_q};
		end
	end

	assign stk_raddr = cmd.check ? 6'(depth_after - 7'd1) : cnt_q;

	gmdp_ram #(.WIDTH(1), .DEPTH(gmdp_pkg::CELLS)) u_open_ram (
		.clk   (clk),
		.we    (open_we),
		.waddr (open_waddr),
		.wdata (open_wdata),
		.raddr (open_raddr),
		.rdata (open_rd)
	);

	gmdp_ram #(.WIDTH(1), .DEPTH(gmdp_pkg::CELLS)) u_visit_ram (
		.clk   (clk),
		.we    (vis_we),
		.waddr (vis_waddr),
		.wdata (vis_wdata),
		.raddr ({nb_r, nb_c}),
		.rdata (vis_rd)
	);

	gmdp_ram #(.WIDTH(gmdp_pkg::ENTRY_W), .DEPTH(gmdp_pkg::CELLS)) u_stack_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.raddr (stk_raddr),
		.rdata (stk_rd)
	);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q     <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.sweep_open || cmd.sweep_visit || cmd.out_path) begin
				cnt_q <= cnt_q + 6'd1;
			end else if (cmd.start || (cmd.check && hit)) begin
				cnt_q <= '0;
			end

			if (cmd.start || cmd.out_last || cmd.out_fail) begin
				depth_q <= '0;
			end else if (cmd.init && open_rd) begin
				depth_q <= 7'd1;
			end else if (cmd.check && push) begin
				depth_q <= depth_after + 7'd1;
			end else if (cmd.check && popped) begin
				depth_q <= depth_after;
			end

			if (cmd.out_path || cmd.out_last || cmd.out_fail) begin
				out_valid_q <= 1'b1;
			end else if (!path_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// search payload registers
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			trow_q <= target_row;
			tcol_q <= target_col;
		end
		if (cmd.init) begin
			top_cell_q <= '0;
			top_dir_q  <= gmdp_pkg::DIR_RIGHT;
		end else if (cmd.step) begin
			nb_cell_q   <= {nb_r, nb_c};
			nb_inside_q <= nb_in;
			nb_dir3_q   <= (top_dir_q == gmdp_pkg::DIR_UP);
			nb_tgt_q    <= (nb_r == trow_q) && (nb_c == tcol_q);
			top_dir_q   <= top_dir_q + 2'd1;
		end else if (cmd.check && push) begin
			top_cell_q <= nb_cell_q;
			top_dir_q  <= gmdp_pkg::DIR_RIGHT;
		end else if (cmd.pop) begin
			top_cell_q <= stk_rd[5:0];
			top_dir_q  <= stk_rd[7:6];
		end

		if (cmd.out_path) begin
			out_row_q   <= stk_rd[5:3];
			out_col_q   <= stk_rd[2:0];
			out_found_q <= 1'b1;
			out_last_q  <= 1'b0;
		end else if (cmd.out_last) begin
			out_row_q   <= trow_q;
			out_col_q   <= tcol_q;
			out_found_q <= 1'b1;
			out_last_q  <= 1'b1;
		end else if (cmd.out_fail) begin
			out_row_q   <= 3'd0;
			out_col_q   <= 3'd0;
			out_found_q <= 1'b0;
			out_last_q  <= 1'b1;
		end
	end

	assign path_valid = out_valid_q;
	assign path_row   = out_row_q;
	assign path_col   = out_col_q;
	assign found      = out_found_q;
	assign last       = out_last_q;

endmodule

// ===== src/grid_maze_dfs_path.sv =====
// top level of the depth-first grid maze path search
// A load word writes one open or blocked bit of the grid and is taken without leaving idle. A
// search word from (0,0) to the target first clears the visited map, then probes each neighbour
// in a step state (neighbour read from the grid and visited maps) and a check state (decision),
// plus a pop state per backtrack to re-read the stack; it returns the path from the start to
// the target, each cell read from the stack and then written out, the last word marked, or one
// word with found low when no path exists. A search to (0,0) returns only the last word, with
// no search. Words are taken one at a time, the next while the final result still waits in the
// output register. After reset the grid is cleared while item_stall stays high.
module grid_maze_dfs_path #(
	parameter int GRID_SIZE = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	input  logic       func,
	input  logic [2:0] cell_row,
	input  logic [2:0] cell_col,
	input  logic       cell_open,
	input  logic [2:0] target_row,
	input  logic [2:0] target_col,
	output logic       path_valid,
	input  logic       path_stall,
	output logic [2:0] path_row,
	output logic [2:0] path_col,
	output logic       found,
	output logic       last
);

	gmdp_pkg::cmd_t cmd;
	gmdp_pkg::sts_t sts;

	gmdp_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.func       (func),
		.sts        (sts),
		.item_stall (item_stall),
		.cmd        (cmd)
	);

	gmdp_datapath #(.GRID_SIZE(GRID_SIZE)) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.cell_row   (cell_row),
		.cell_col   (cell_col),
		.cell_open  (cell_open),
		.target_row (target_row),
		.target_col (target_col),
		.path_stall (path_stall),
		.sts        (sts),
		.path_valid (path_valid),
		.path_row   (path_row),
		.path_col   (path_col),
		.found      (found),
		.last       (last)
	);

endmodule
